@@ hdl/dtpt_pkg.sv @@
// Shared types and constants for the debounced threshold period timer.
`timescale 1ns / 1ps

package dtpt_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned HITS_W   = 8;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned PHASE_W  = 3;

    // Stream word widths (whole bytes)
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 24;

    // Configuration port widths
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // Register indexes (paddr[2])
    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_HITS_NEEDED = 1'b1;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST   = 12'h200;
    localparam logic [HITS_W-1:0]   HITS_NEEDED_RST = 8'd5;

    // Hit counter saturation value
    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

    // Input word kinds
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_WAIT_LOW  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEB_LOW   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FALL_DONE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_HIGH = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DEB_HIGH  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RISE_DONE = 3'd5;

    // One result word
    typedef struct packed {
        logic                period_valid;
        logic [PERIOD_W-1:0] period;
        logic                indicator;
    } result_t;

endpackage

@@ hdl/debounced_threshold_period_timer.sv @@
// Top level of the debounced threshold period timer.
`timescale 1ns / 1ps
//
//  Channel  Direction  Payload
//  s_       in         tuser: opcode; tdata: sample
//  m_       out        tuser: period_valid; tdata: period, indicator
//  APB      in/out     threshold at 0x0, hits needed at 0x4
//
//  The state update and the result for a word are formed by one compare and
//  one small counter step between the state registers and the result
//  register. A word is accepted every cycle while the skid register is
//  empty; a stalled result moves into the skid register and s_tready drops
//  for as long as it is occupied. Reset is synchronous and active low.

module debounced_threshold_period_timer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dtpt_pkg::S_DATA_W-1:0]  s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                           s_tuser,   // [0] opcode
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dtpt_pkg::M_DATA_W-1:0]  m_tdata,   // [15:0] period, [16] indicator,
                                                      // [23:17] zero
    output logic                           m_tuser,   // [0] period_valid
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dtpt_pkg::ADDR_W-1:0]    paddr,
    input  logic [dtpt_pkg::DATA_W-1:0]    pwdata,
    output logic [dtpt_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import dtpt_pkg::*;

    // Configuration registers
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [HITS_W-1:0]   hits_needed_reg;

    // Machine state
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [HITS_W-1:0]   low_hits_reg, low_hits_next;
    logic [HITS_W-1:0]   high_hits_reg, high_hits_next;
    logic [PERIOD_W-1:0] tick_count_reg, tick_count_next;
    logic                indicator_reg, indicator_next;

    // Output and skid registers
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic                s_accept;
    logic                out_free;
    logic                cfg_write;
    logic                is_low;
    logic [SAMPLE_W-1:0] sample;
    logic [HITS_W-1:0]   low_bump;
    logic [HITS_W-1:0]   high_bump;
    result_t             result;

    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read-back
    always_comb begin
        unique case (paddr[2])
            REG_THRESHOLD:   prdata = DATA_W'(threshold_reg);
            REG_HITS_NEEDED: prdata = DATA_W'(hits_needed_reg);
            default:         prdata = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= THRESHOLD_RST;
            hits_needed_reg <= HITS_NEEDED_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_THRESHOLD) begin
                threshold_reg <= pwdata[SAMPLE_W-1:0];
            end else begin
                hits_needed_reg <= pwdata[HITS_W-1:0];
            end
        end
    end

    // Classify the sample and form saturating hit increments
    assign sample    = s_tdata[SAMPLE_W-1:0];
    assign is_low    = sample < threshold_reg;
    assign low_bump  = (low_hits_reg == HITS_MAX) ? HITS_MAX : low_hits_reg + 1'b1;
    assign high_bump = (high_hits_reg == HITS_MAX) ? HITS_MAX : high_hits_reg + 1'b1;

    // Advance the phase machine for one word
    always_comb begin
        phase_next      = phase_reg;
        low_hits_next   = low_hits_reg;
        high_hits_next  = high_hits_reg;
        tick_count_next = tick_count_reg;
        indicator_next  = indicator_reg;
        result.period_valid = 1'b0;
        result.period       = '0;

        if (s_tuser == OP_TICK) begin
            tick_count_next = tick_count_reg + 1'b1;
        end else begin
            unique case (phase_reg)
                PH_WAIT_LOW: begin
                    if (is_low) begin
                        phase_next     = PH_DEB_LOW;
                        low_hits_next  = HITS_W'(1);
                        high_hits_next = '0;
                    end
                end
                PH_DEB_LOW: begin
                    if (is_low) begin
                        low_hits_next = low_bump;
                        if (low_bump >= hits_needed_reg) begin
                            phase_next = PH_FALL_DONE;
                        end
                    end else begin
                        low_hits_next = '0;
                    end
                end
                PH_FALL_DONE: begin
                    result.period_valid = 1'b1;
                    result.period       = tick_count_reg;
                    tick_count_next     = '0;
                    indicator_next      = 1'b1;
                    phase_next          = PH_WAIT_HIGH;
                end
                PH_WAIT_HIGH: begin
                    if (!is_low) begin
                        phase_next     = PH_DEB_HIGH;
                        low_hits_next  = '0;
                        high_hits_next = HITS_W'(1);
                    end
                end
                PH_DEB_HIGH: begin
                    if (!is_low) begin
                        high_hits_next = high_bump;
                        if (high_bump >= hits_needed_reg) begin
                            phase_next = PH_RISE_DONE;
                        end
                    end else begin
                        high_hits_next = '0;
                    end
                end
                PH_RISE_DONE: begin
                    indicator_next = 1'b0;
                    phase_next     = PH_WAIT_LOW;
                end
                default: begin
                    phase_next = PH_WAIT_LOW;
                end
            endcase
        end
        result.indicator = indicator_next;
    end

    // Commit state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT_LOW;
            low_hits_reg   <= '0;
            high_hits_reg  <= '0;
            tick_count_reg <= '0;
            indicator_reg  <= 1'b0;
        end else if (s_accept) begin
            phase_reg      <= phase_next;
            low_hits_reg   <= low_hits_next;
            high_hits_reg  <= high_hits_next;
            tick_count_reg <= tick_count_next;
            indicator_reg  <= indicator_next;
        end
    end

    // Route results through the output and skid registers
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (s_accept) begin
            if (out_free) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.period_valid;
    assign m_tdata  = {{(M_DATA_W - PERIOD_W - 1){1'b0}},
                       out_data_reg.indicator, out_data_reg.period};

endmodule

@@ hdl/dtpt_checker.sv @@
// Port-level checks for the debounced threshold period timer, bound to the top level.
`timescale 1ns / 1ps

module dtpt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dtpt_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                           m_tuser
);
    import dtpt_pkg::*;

    // Reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // A reported period always comes with the indicator lit
    a_period_lights: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[PERIOD_W])
        else $error("period reported with indicator dark");

    // Without a report the period field is zero
    a_period_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[PERIOD_W-1:0] == '0))
        else $error("nonzero period without report");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

    // Input is taken again once the stalled result drains
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && m_tready) |=> s_tready)
        else $error("input not resumed after drain");

endmodule

bind debounced_threshold_period_timer dtpt_checker u_dtpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
